/* hdl/yuyv_to_rgb565_converter_top_macros.svh */
// Assertion macros for the YUYV to RGB565 converter.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef YUYV_TO_RGB565_CONVERTER_TOP_MACROS_SVH
`define YUYV_TO_RGB565_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define YUYV2RGB_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed: consequent missing in same cycle");

// Next-cycle implication, checked out of reset.
`define YUYV2RGB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed: consequent missing in next cycle");

`endif

/* hdl/yuyv2rgb_pkg.sv */
// Types, coefficients and helpers for the YUYV to RGB565 converter.
// No dependencies; imported by the converter top level.
`default_nettype none

package yuyv2rgb_pkg;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } yuyv_t;

  typedef struct packed {
    logic [15:0] pixel_first;
    logic [15:0] pixel_second;
  } rgb_pair_t;

  localparam logic [7:0] CHROMA_OFFSET = 8'd128;

  // Fixed-point coefficients, scaled by 256
  localparam logic signed [8:0] COEF_R_CR = 9'sd104;
  localparam logic signed [8:0] COEF_G_CB = 9'sd89;
  localparam logic signed [8:0] COEF_G_CR = 9'sd183;
  localparam logic signed [8:0] COEF_B_CB = 9'sd199;

  localparam int unsigned CHAN_W = 11;  // signed channel sum before clamping
  localparam int unsigned PROD_W = 18;  // 9x9 signed product

  function automatic logic [7:0] sat8(input logic signed [CHAN_W-1:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > $signed(CHAN_W'(255))) begin
      res = 8'hFF;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

`default_nettype wire

/* hdl/yuyv_to_rgb565_converter_top.sv */
// YUYV 4:2:2 to RGB565 converter, four register stages.
// Depends on yuyv2rgb_pkg and yuyv_to_rgb565_converter_top_macros.svh.
// Takes one YUYV group per clock unless in_stall; returns one item of two RGB565 pixels.
// Four register stages: chroma offset, coefficient multiply, channel sums, then clamp and
// pack into the output register; out_valid rises once the accepted group leaves stage 3.
// Each stage has its own valid bit and advances whenever the stage after it is empty or
// moving, so bubbles are squeezed out and in_stall rises only when every stage is full and
// out_stall holds the output item. Sustained rate is one item per cycle unless out_stall.
`default_nettype none

module yuyv_to_rgb565_converter_top (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire yuyv2rgb_pkg::yuyv_t      in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output yuyv2rgb_pkg::rgb_pair_t       out_data
);

  import yuyv2rgb_pkg::*;

  `include "yuyv_to_rgb565_converter_top_macros.svh"

  // stage enables
  logic en1, en2, en3, en_o;

  // stage 1: offset-removed chroma
  logic                    v1_r;
  logic [7:0]              y0_1_r, y1_1_r;
  logic signed [8:0]       d_1_r, e_1_r;

  // stage 2: products
  logic                    v2_r;
  logic [7:0]              y0_2_r, y1_2_r;
  logic signed [8:0]       d_2_r, e_2_r;
  logic signed [PROD_W-1:0] prc_2_r, pgb_2_r, pgr_2_r, pbb_2_r;

  // stage 3: unclamped channels, shared chroma terms
  logic                    v3_r;
  logic signed [CHAN_W-1:0] r0_3_r, g0_3_r, b0_3_r, r1_3_r, g1_3_r, b1_3_r;

  // output register
  logic                    out_valid_r;
  rgb_pair_t               out_data_r;

  // chroma contributions, shared by both pixels
  logic signed [CHAN_W-1:0] r_add, g_add, b_add;
  logic signed [CHAN_W-1:0] y0_s, y1_s;

  assign en_o = !out_valid_r || !out_stall;
  assign en3  = !v3_r || en_o;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;

  assign in_stall  = !en1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    r_add = CHAN_W'(d_2_r) + CHAN_W'(prc_2_r >>> 8);
    g_add = -CHAN_W'(pgb_2_r >>> 8) - CHAN_W'(pgr_2_r >>> 8);
    b_add = CHAN_W'(e_2_r) + CHAN_W'(pbb_2_r >>> 8);
    y0_s  = $signed({{(CHAN_W-8){1'b0}}, y0_2_r});
    y1_s  = $signed({{(CHAN_W-8){1'b0}}, y1_2_r});
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)  v1_r        <= in_valid;
      if (en2)  v2_r        <= v1_r;
      if (en3)  v3_r        <= v2_r;
      if (en_o) out_valid_r <= v3_r;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (en1) begin
      y0_1_r <= in_data.luma_first;
      y1_1_r <= in_data.luma_second;
      d_1_r  <= $signed({1'b0, in_data.chroma_red})  - $signed({1'b0, CHROMA_OFFSET});
      e_1_r  <= $signed({1'b0, in_data.chroma_blue}) - $signed({1'b0, CHROMA_OFFSET});
    end
    if (en2) begin
      y0_2_r  <= y0_1_r;
      y1_2_r  <= y1_1_r;
      d_2_r   <= d_1_r;
      e_2_r   <= e_1_r;
      prc_2_r <= PROD_W'(d_1_r) * PROD_W'(COEF_R_CR);
      pgb_2_r <= PROD_W'(e_1_r) * PROD_W'(COEF_G_CB);
      pgr_2_r <= PROD_W'(d_1_r) * PROD_W'(COEF_G_CR);
      pbb_2_r <= PROD_W'(e_1_r) * PROD_W'(COEF_B_CB);
    end
    if (en3) begin
      r0_3_r <= y0_s + r_add;
      g0_3_r <= y0_s + g_add;
      b0_3_r <= y0_s + b_add;
      r1_3_r <= y1_s + r_add;
      g1_3_r <= y1_s + g_add;
      b1_3_r <= y1_s + b_add;
    end
    if (en_o) begin
      out_data_r.pixel_first  <= pack565(sat8(r0_3_r), sat8(g0_3_r), sat8(b0_3_r));
      out_data_r.pixel_second <= pack565(sat8(r1_3_r), sat8(g1_3_r), sat8(b1_3_r));
    end
  end

  // input only backs up when the whole pipe is full behind a held output
  `YUYV2RGB_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, in_stall,
                        out_valid && out_stall && v1_r && v2_r && v3_r)
  // an accepted item always lands in stage 1
  `YUYV2RGB_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && !in_stall, v1_r)
  // a stage 3 item that moves always reaches the output register
  `YUYV2RGB_ASSERT_NEXT(a_s3_to_out, clk, rst_n, v3_r && en_o, out_valid)

endmodule

`default_nettype wire

/* dv/yuyv_to_rgb565_converter_top_test.sv */
// Self-checking bench for the YUYV to RGB565 converter: directed corners, then random groups.
// Depends on yuyv2rgb_pkg and the converter top level; expected pixels come from a local
// integer predictor, compared in order against every item the block returns.
`timescale 1ns / 100ps

module yuyv_to_rgb565_converter_top_test;
  import yuyv2rgb_pkg::*;

  localparam int RANDOM_GROUPS = 1950;
  localparam int DRAIN_CYCLES  = 12;
  localparam int HOLD_CYCLES   = 150;
  localparam int TIMEOUT_NS    = 5_000_000;

  // Idle styles for both sides
  typedef enum int {IDLE_RANDOM, IDLE_NONE, IDLE_SPARSE} idle_style_t;

  class rgb565_checker;
    rgb_pair_t expected_pairs[$];
    int fail_count = 0;

    static function int clamp_byte(input int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
    endfunction

    // Integer math throughout so that >>> is an arithmetic shift (floor by 256)
    static function logic [15:0] convert_pixel(input logic [7:0] y, input logic [7:0] cb,
                                               input logic [7:0] cr);
      int yi, e, d;
      logic [7:0] r, g, b;
      yi = int'(y);
      e = int'(cb) - 128;
      d = int'(cr) - 128;
      r = 8'(clamp_byte(yi + d + ((d * 104) >>> 8)));
      g = 8'(clamp_byte(yi - ((e * 89) >>> 8) - ((d * 183) >>> 8)));
      b = 8'(clamp_byte(yi + e + ((e * 199) >>> 8)));
      return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function void note_group(input yuyv_t grp);
      rgb_pair_t p;
      p.pixel_first  = convert_pixel(grp.luma_first, grp.chroma_blue, grp.chroma_red);
      p.pixel_second = convert_pixel(grp.luma_second, grp.chroma_blue, grp.chroma_red);
      expected_pairs.push_back(p);
    endfunction

    function void check_pair(input rgb_pair_t got);
      rgb_pair_t want;
      if (expected_pairs.size() == 0) begin
        $error("item with nothing expected: %h", got);
        fail_count++;
        return;
      end
      want = expected_pairs.pop_front();
      if (got.pixel_first !== want.pixel_first) begin
        $error("pixel_first: expected %h, got %h", want.pixel_first, got.pixel_first);
        fail_count++;
      end
      if (got.pixel_second !== want.pixel_second) begin
        $error("pixel_second: expected %h, got %h", want.pixel_second, got.pixel_second);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  yuyv_t     in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rgb_pair_t out_data;

  rgb565_checker chk = new();
  int results_seen = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  yuyv_to_rgb565_converter_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  function automatic int draw_wait(input idle_style_t style);
    case (style)
      IDLE_NONE: begin
        return 0;
      end
      IDLE_SPARSE: begin
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      end
      default: begin
        return $urandom_range(0, 19);
      end
    endcase
  endfunction

  function automatic idle_style_t draw_style();
    return idle_style_t'($urandom_range(0, 2));
  endfunction

  // Mostly uniform bytes, now and then one of the interesting edge values
  function automatic logic [7:0] draw_byte();
    logic [7:0] edge_vals [7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
    if ($urandom_range(0, 7) == 0) return edge_vals[$urandom_range(0, 6)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one group after the given gap; valid stays high across back-to-back items
  task automatic send_group(input yuyv_t grp, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= grp;
    do @(posedge clk); while (!(in_valid && !in_stall));
    chk.note_group(grp);
  endtask

  // Result side: random stalls, with two long hold-offs to back the pipe up
  initial begin
    int hold;
    idle_style_t style;
    style = IDLE_RANDOM;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (results_seen % 64 == 0) style = draw_style();
      if (results_seen == 400 || results_seen == 1300) begin
        hold = HOLD_CYCLES;
      end else begin
        hold = draw_wait(style);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      chk.check_pair(out_data);
      results_seen++;
    end
  end

  initial begin
    logic [31:0] corner_groups [20];
    yuyv_t grp;
    idle_style_t style;
    int drain;

    corner_groups = '{
      32'h00_00_00_00, 32'hFF_FF_FF_FF, 32'h00_80_FF_80, 32'h80_80_80_80,
      32'hFF_00_00_FF, 32'h00_FF_FF_00, 32'hFF_00_FF_00, 32'h00_FF_00_FF,
      32'h10_7F_EB_7F, 32'h10_81_EB_81, 32'h40_7E_C0_82, 32'hFF_80_00_80,
      32'h01_55_FE_AA, 32'hFE_AA_01_55, 32'hEB_F0_10_10, 32'h10_10_EB_F0,
      32'h7F_01_80_FE, 32'h00_80_00_FF, 32'hA5_5A_A5_5A, 32'h5A_A5_5A_A5
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corners: neutral chroma, both chroma extremes, floor on negative products, clamping
    foreach (corner_groups[i]) begin
      send_group(yuyv_t'(corner_groups[i]), (i < 10) ? 0 : $urandom_range(0, 4));
    end

    style = IDLE_RANDOM;
    for (int n = 0; n < RANDOM_GROUPS; n++) begin
      if (n % 64 == 0) style = draw_style();
      grp.luma_first  = draw_byte();
      grp.chroma_blue = draw_byte();
      grp.luma_second = draw_byte();
      grp.chroma_red  = draw_byte();
      send_group(grp, draw_wait(style));
    end
    in_valid <= 1'b0;

    while (chk.pending() != 0) @(posedge clk);
    drain = DRAIN_CYCLES;
    repeat (drain) @(posedge clk);

    if (chk.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
